>>> hw/rtl/rpsa_pkg.sv
// Shared constants for the region probe slot allocator.
// Table geometry, field widths, mode and status codes.
// No dependencies.
`timescale 1ns / 1ps

package rpsa_pkg;

	localparam int MAX_ENTRIES   = 65536;
	localparam int REGION_SLOTS  = 64;
	localparam int IDX_W         = $clog2(MAX_ENTRIES);
	localparam int OFF_W         = $clog2(REGION_SLOTS);
	localparam int OCC_DEPTH     = MAX_ENTRIES / REGION_SLOTS;
	localparam int OCC_ADDR_W    = IDX_W - OFF_W;
	localparam int CNT_W         = IDX_W + 1;
	localparam int FP_W          = 64;
	localparam int BLK_W         = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_BAD   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_OCCUPIED  = 3'd2,
		ST_FREE      = 3'd3,
		ST_BAD       = 3'd4
	} status_t;

endpackage

>>> hw/rtl/rpsa_mod.sv
// Iterative remainder unit: 64-bit dividend modulo a 17-bit count, two bits per cycle.
// Depends on rpsa_pkg.
`timescale 1ns / 1ps

module rpsa_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rpsa_pkg::FP_W-1:0]    dividend,
	input  logic [rpsa_pkg::CNT_W-1:0]   divisor,
	output logic                         done,
	output logic [rpsa_pkg::IDX_W-1:0]   remainder
);
	import rpsa_pkg::*;

	localparam int STEPS   = FP_W / 2;
	localparam int STEP_W  = $clog2(STEPS);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [FP_W-1:0]     dvd_q;
	logic [CNT_W-1:0]    div_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    r1;
	logic [CNT_W-1:0]    r2;

	// one restoring step: shift in a bit, subtract if it fits
	function automatic logic [CNT_W-1:0] mod_step(input logic [CNT_W-1:0] r,
			input logic b, input logic [CNT_W-1:0] d);
		logic [CNT_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[CNT_W-1:0];
	endfunction

	assign r1 = mod_step(rem_q, dvd_q[FP_W-1], div_q);
	assign r2 = mod_step(r1, dvd_q[FP_W-2], div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[FP_W-3:0], 2'b00};
			rem_q <= r2;
		end
	end

	assign done      = done_q;
	// remainder is below the divisor, which never exceeds MAX_ENTRIES
	assign remainder = rem_q[IDX_W-1:0];

endmodule

>>> hw/rtl/region_probe_slot_allocator_core.sv
// Region probe slot allocator, top level.
// Alloc: the two-bit-per-cycle remainder unit finds the home slot, then occupancy
//   read, mask and search lead to the done strobe; write and free do one
//   read-modify-write of the slot memories.
// Throughput: one word at a time; busy stays high until the done strobe. Reset: a
//   clearing pass sweeps the occupancy memory to zero, busy high.
`timescale 1ns / 1ps

module region_probe_slot_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [rpsa_pkg::FP_W-1:0]     fingerprint,
	input  logic [rpsa_pkg::IDX_W-1:0]    entry_index,
	input  logic [rpsa_pkg::BLK_W-1:0]    block_number,
	// result, one-cycle strobe
	output logic                          done,
	output logic [2:0]                    status,
	output logic [rpsa_pkg::IDX_W-1:0]    slot,
	output logic [rpsa_pkg::BLK_W-1:0]    freed_block,
	// num_entries register
	input  logic                          cfg_we,
	input  logic [rpsa_pkg::CNT_W-1:0]    cfg_wdata
);
	import rpsa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_ARD,
		S_AMASK,
		S_AFIND,
		S_MCHK
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        num_entries_q;
	logic [OCC_ADDR_W-1:0]   clr_addr_q;

	// latched word
	logic [1:0]              mode_q;
	logic [IDX_W-1:0]        idx_q;
	logic [BLK_W-1:0]        blk_q;
	logic [CNT_W-1:0]        n_q;
	logic [IDX_W-1:0]        home_q;
	logic [REGION_SLOTS-1:0] rot_q;

	// result registers
	logic                    done_q;
	logic [2:0]              status_q;
	logic [IDX_W-1:0]        slot_q;
	logic [BLK_W-1:0]        freed_q;

	// memories: occupancy bitmap per region, block number per slot.
	// slot_mem is only trusted where the occupancy bit is set, so it needs
	// no clearing; the bitmap is swept to zero after reset.
	logic [REGION_SLOTS-1:0] occ_mem [OCC_DEPTH];
	logic [BLK_W-1:0]        slot_mem [MAX_ENTRIES];
	logic [REGION_SLOTS-1:0] occ_rdata_q;
	logic [BLK_W-1:0]        slot_rdata_q;
	logic [OCC_ADDR_W-1:0]   occ_raddr;
	logic                    occ_we;
	logic [OCC_ADDR_W-1:0]   occ_waddr;
	logic [REGION_SLOTS-1:0] occ_wdata;
	logic                    slot_we;

	logic                    accept;
	logic [CNT_W-1:0]        n_eff;
	logic                    div_done;
	logic [IDX_W-1:0]        div_rem;

	// check stage (write/free)
	logic [OFF_W-1:0]        bit_sel;
	logic                    occ_bit;
	logic                    bad_idx;
	logic [2:0]              mchk_status;
	logic                    mchk_commit;

	// alloc search
	logic [CNT_W-1:0]        lim;
	logic [REGION_SLOTS-1:0] avail;
	logic [2*REGION_SLOTS-1:0] avail2;
	logic [REGION_SLOTS-1:0] rot;
	logic                    found;
	logic [OFF_W-1:0]        first_pos;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// effective entry count: zero reads as one, clamp at table size
	always_comb begin
		if (num_entries_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (num_entries_q > CNT_MAX) begin
			n_eff = CNT_MAX;
		end else begin
			n_eff = num_entries_q;
		end
	end

	rpsa_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && (mode == MODE_ALLOC)),
		.dividend  (fingerprint),
		.divisor   (n_eff),
		.done      (div_done),
		.remainder (div_rem)
	);

	// ---- memory ports ----
	assign occ_raddr = (state_q == S_IDLE) ? entry_index[IDX_W-1:OFF_W]
	                                       : home_q[IDX_W-1:OFF_W];

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		occ_rdata_q <= occ_mem[occ_raddr];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[idx_q] <= blk_q;
		end
		slot_rdata_q <= slot_mem[entry_index];
	end

	// ---- write / free check ----
	assign bit_sel = idx_q[OFF_W-1:0];
	assign occ_bit = occ_rdata_q[bit_sel];
	assign bad_idx = ({1'b0, idx_q} >= n_q);

	always_comb begin
		mchk_status = ST_BAD;
		mchk_commit = 1'b0;
		case (mode_q)
			MODE_WRITE: begin
				if (bad_idx || (blk_q == '0)) begin
					mchk_status = ST_BAD;
				end else if (occ_bit) begin
					mchk_status = ST_OCCUPIED;
				end else begin
					mchk_status = ST_OK;
					mchk_commit = 1'b1;
				end
			end
			MODE_FREE: begin
				if (bad_idx) begin
					mchk_status = ST_BAD;
				end else if (!occ_bit) begin
					mchk_status = ST_FREE;
				end else begin
					mchk_status = ST_OK;
					mchk_commit = 1'b1;
				end
			end
			default: begin
				mchk_status = ST_BAD;
			end
		endcase
	end

	always_comb begin
		occ_we    = 1'b0;
		occ_waddr = idx_q[IDX_W-1:OFF_W];
		occ_wdata = occ_rdata_q;
		slot_we   = 1'b0;
		if (state_q == S_CLEAR) begin
			occ_we    = 1'b1;
			occ_waddr = clr_addr_q;
			occ_wdata = '0;
		end else if ((state_q == S_MCHK) && mchk_commit) begin
			occ_we = 1'b1;
			if (mode_q == MODE_WRITE) begin
				occ_wdata[bit_sel] = 1'b1;
				slot_we            = 1'b1;
			end else begin
				occ_wdata[bit_sel] = 1'b0;
			end
		end
	end

	// ---- alloc search ----
	// slots past the entry count (partial last region) read as taken
	assign lim = n_q - {1'b0, home_q[IDX_W-1:OFF_W], {OFF_W{1'b0}}};

	always_comb begin
		for (int i = 0; i < REGION_SLOTS; i++) begin
			avail[i] = !occ_rdata_q[i] && (CNT_W'(i) < lim);
		end
	end

	// rotate so the home offset sits at bit 0; wrap comes for free
	assign avail2 = {avail, avail} >> home_q[OFF_W-1:0];
	assign rot    = avail2[REGION_SLOTS-1:0];

	always_comb begin
		first_pos = '0;
		for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
			if (rot_q[i]) begin
				first_pos = OFF_W'(i);
			end
		end
	end
	assign found = |rot_q;

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			num_entries_q <= CNT_MAX;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				num_entries_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {OCC_ADDR_W{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (mode == MODE_ALLOC) ? S_DIV : S_MCHK;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ARD;
					end
				end
				S_ARD: begin
					state_q <= S_AMASK;
				end
				S_AMASK: begin
					state_q <= S_AFIND;
				end
				S_AFIND: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MCHK: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			idx_q  <= entry_index;
			blk_q  <= block_number;
			n_q    <= n_eff;
		end
		if ((state_q == S_DIV) && div_done) begin
			home_q <= div_rem;
		end
		if (state_q == S_AMASK) begin
			rot_q <= rot;
		end
		if (state_q == S_AFIND) begin
			freed_q <= '0;
			if (found) begin
				status_q <= ST_OK;
				slot_q   <= {home_q[IDX_W-1:OFF_W], first_pos + home_q[OFF_W-1:0]};
			end else begin
				status_q <= ST_FULL;
				slot_q   <= home_q;
			end
		end else if (state_q == S_MCHK) begin
			status_q <= mchk_status;
			slot_q   <= idx_q;
			freed_q  <= (mchk_commit && (mode_q == MODE_FREE)) ? slot_rdata_q : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign freed_block = freed_q;

	// ---- checks ----
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	a_freed_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (freed_block == '0))
		else $error("freed block on failed word");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("remainder done outside alloc wait");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!occ_we && !slot_we))
		else $error("memory written while idle");

endmodule

>>> tb/tb_top.sv
// Testbench for the region probe slot allocator core.
// Holds its own slot table model and checks every result word; needs only rpsa_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
	import rpsa_pkg::*;

	// Watchdog: cycles with neither an accepted command nor a done strobe.
	// The limit sits well above both the reset clearing pass and an alloc
	// plus the longest sender gap.
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		status_t            code;
		logic [IDX_W-1:0]   slot_no;
		logic [BLK_W-1:0]   freed_blk;
	} probe_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         mode = MODE_ALLOC;
	logic [FP_W-1:0]    fingerprint = '0;
	logic [IDX_W-1:0]   entry_index = '0;
	logic [BLK_W-1:0]   block_number = '0;
	logic               done;
	logic [2:0]         status;
	logic [IDX_W-1:0]   slot;
	logic [BLK_W-1:0]   freed_block;
	logic               cfg_we = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;

	// Slot table model: block number per slot, zero means free.
	// Occupancy is simply (block != 0), so no separate bitmap is kept.
	bit [BLK_W-1:0]     model_blocks [MAX_ENTRIES];
	logic [CNT_W-1:0]   model_count = CNT_MAX;

	probe_result_t      pending_results [$];
	logic [IDX_W-1:0]   held_slots [$];     // slots committed by a write and not yet freed
	bit                 start_hi = 1'b0;    // mirrors what start was last driven to
	int unsigned        burst_left = 0;
	int unsigned        mismatches = 0;
	int unsigned        stall_cycles = 0;

	region_probe_slot_allocator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.fingerprint  (fingerprint),
		.entry_index  (entry_index),
		.block_number (block_number),
		.done         (done),
		.status       (status),
		.slot         (slot),
		.freed_block  (freed_block),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// Effective entry count: zero acts as one, anything above the table as the table size.
	function automatic int unsigned live_count();
		if (model_count == '0)
			return 1;
		if (model_count > CNT_MAX)
			return MAX_ENTRIES;
		return int'(model_count);
	endfunction

	// Expected result of one command word; also applies its effect to the table.
	function automatic probe_result_t predict_result(mode_t m, logic [FP_W-1:0] fp,
			logic [IDX_W-1:0] idx, logic [BLK_W-1:0] blk);
		probe_result_t r;
		int unsigned   n;
		int unsigned   home;
		int unsigned   off;
		int unsigned   base;
		int unsigned   s;
		bit            found;
		n = live_count();
		r.code = ST_BAD;
		r.slot_no = idx;
		r.freed_blk = '0;
		case (m)
			MODE_ALLOC: begin
				// home slot, then probe its aligned region with wrap; slots past n are taken
				home = int'(fp % 64'(n));
				off = home % REGION_SLOTS;
				base = home - off;
				r.code = ST_FULL;
				r.slot_no = IDX_W'(home);
				found = 1'b0;
				for (int i = 0; i < REGION_SLOTS; i++) begin
					s = base + (off + i) % REGION_SLOTS;
					if (!found && s < n && model_blocks[s] == '0) begin
						found = 1'b1;
						r.code = ST_OK;
						r.slot_no = IDX_W'(s);
					end
				end
			end
			MODE_WRITE: begin
				// bad index, then zero block, then occupied
				if (idx >= n || blk == '0)
					r.code = ST_BAD;
				else if (model_blocks[idx] != '0)
					r.code = ST_OCCUPIED;
				else begin
					model_blocks[idx] = blk;
					r.code = ST_OK;
				end
			end
			MODE_FREE: begin
				if (idx >= n)
					r.code = ST_BAD;
				else if (model_blocks[idx] == '0)
					r.code = ST_FREE;
				else begin
					r.freed_blk = model_blocks[idx];
					model_blocks[idx] = '0;
					r.code = ST_OK;
				end
			end
			default: r.code = ST_BAD;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking and watchdog
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Outputs are sampled at the edge that ends the strobe cycle, before the
	// core's own updates for that edge land.
	always @(posedge clk) begin : check_results
		probe_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0)
				flag_mismatch("unexpected word, slot", 32'(slot), 32'(0));
			else begin
				want = pending_results.pop_front();
				if (status !== want.code)
					flag_mismatch("status", 32'(status), 32'(want.code));
				if (slot !== want.slot_no)
					flag_mismatch("slot", 32'(slot), 32'(want.slot_no));
				if (freed_block !== want.freed_blk)
					flag_mismatch("freed_block", freed_block, want.freed_blk);
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Command driving
	// ------------------------------------------------------------------

	// Sender gap per word: mostly random, with occasional back-to-back bursts.
	function automatic int unsigned next_gap();
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// Send one word, wait for its accept, record the expected result.
	// start stays high on a zero gap so it is never lowered and raised in one step.
	task automatic issue_word(input mode_t m, input logic [FP_W-1:0] fp,
			input logic [IDX_W-1:0] idx, input logic [BLK_W-1:0] blk,
			output probe_result_t r);
		int unsigned gap;
		int          k;
		gap = next_gap();
		if (gap != 0) begin
			if (start_hi)
				start <= 1'b0;
			start_hi = 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		start_hi = 1'b1;
		mode <= m;
		fingerprint <= fp;
		entry_index <= idx;
		block_number <= blk;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		r = predict_result(m, fp, idx, blk);
		pending_results.push_back(r);
		if (m == MODE_WRITE && r.code == ST_OK)
			held_slots.push_back(idx);
		if (m == MODE_FREE && r.code == ST_OK) begin
			k = 0;
			while (k < held_slots.size())
				if (held_slots[k] == idx)
					held_slots.delete(k);
				else
					k++;
		end
	endtask

	// Drop start and wait until every expected word is back and the core is idle.
	task automatic drain_results();
		if (start_hi)
			start <= 1'b0;
		start_hi = 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_entry_count(input logic [CNT_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_count = v;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Full table: alloc, write, free, collisions, zero block, region wrap, bad mode.
	task automatic test_basic_ops();
		probe_result_t r;
		set_entry_count(CNT_MAX);
		issue_word(MODE_ALLOC, '0, '0, '0, r);
		issue_word(MODE_WRITE, '0, 16'd0, 32'd1, r);
		issue_word(MODE_ALLOC, '0, '0, '0, r);                       // slot 0 taken -> 1
		issue_word(MODE_WRITE, '0, 16'd0, '1, r);                    // occupied
		issue_word(MODE_WRITE, '0, 16'd5, '0, r);                    // zero block
		issue_word(MODE_ALLOC, '1, '1, '1, r);                       // home 65535
		issue_word(MODE_WRITE, '0, 16'hFFFF, '1, r);
		issue_word(MODE_ALLOC, '1, '0, '0, r);                       // wraps to region base
		issue_word(MODE_FREE, '0, 16'd0, '0, r);
		issue_word(MODE_FREE, '0, 16'd0, '0, r);                     // already free
		issue_word(MODE_BAD, '1, '1, '1, r);
		issue_word(MODE_FREE, '1, 16'hFFFF, '1, r);
	endtask

	// Count zero behaves as one slot; counts past the table clamp to it.
	task automatic test_count_clamping();
		probe_result_t r;
		set_entry_count('0);
		issue_word(MODE_ALLOC, '1, '0, '0, r);
		issue_word(MODE_WRITE, '0, 16'd1, 32'd7, r);                 // bad index
		issue_word(MODE_WRITE, '0, 16'd0, 32'd7, r);
		issue_word(MODE_ALLOC, {$urandom, $urandom}, '0, '0, r);     // only slot taken: full
		issue_word(MODE_FREE, '0, 16'hFFFF, '0, r);                  // bad index
		set_entry_count('1);
		issue_word(MODE_WRITE, '0, 16'hFFFF, 32'd2, r);
		issue_word(MODE_FREE, '0, 16'hFFFF, '0, r);
	endtask

	// Last region only partly inside the table: slots past the count probe as taken.
	task automatic test_partial_region();
		probe_result_t r;
		set_entry_count(CNT_W'(100));
		issue_word(MODE_ALLOC, 64'd99, '0, '0, r);
		issue_word(MODE_WRITE, '0, 16'd99, 32'd3, r);
		issue_word(MODE_ALLOC, 64'd99, '0, '0, r);                   // wraps to 64
		issue_word(MODE_WRITE, '0, 16'd100, 32'd3, r);               // bad index
		issue_word(MODE_FREE, '0, 16'd99, '0, r);
	endtask

	// One random phase at a given count. Most traffic is alloc followed by a
	// write to the slot it found, aimed at one hot region so regions fill up;
	// the rest frees held slots, writes to arbitrary slots, and noise.
	task automatic random_phase(input logic [CNT_W-1:0] count_value, input int unsigned items);
		probe_result_t    r;
		int unsigned      n;
		int unsigned      hot_base;
		int unsigned      tgt;
		int unsigned      pick;
		int unsigned      sent;
		logic [FP_W-1:0]  fp;
		logic [IDX_W-1:0] idx;
		logic [BLK_W-1:0] blk;
		set_entry_count(count_value);
		n = live_count();
		hot_base = $urandom_range(0, (n - 1) / REGION_SLOTS) * REGION_SLOTS;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			blk = ($urandom_range(0, 19) == 0) ? '0 : BLK_W'($urandom);
			idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, n - 1));
			if (pick < 55) begin
				if ($urandom_range(0, 2) == 0)
					fp = {$urandom, $urandom};
				else begin
					tgt = hot_base + $urandom_range(0, REGION_SLOTS - 1);
					if (tgt >= n)
						tgt = tgt % n;
					fp = 64'($urandom) * 64'(n) + 64'(tgt);
				end
				issue_word(MODE_ALLOC, fp, IDX_W'($urandom), BLK_W'($urandom), r);
				sent++;
				if (r.code == ST_OK && $urandom_range(0, 9) != 0) begin
					issue_word(MODE_WRITE, {$urandom, $urandom}, r.slot_no, blk, r);
					sent++;
				end
			end else if (pick < 80) begin
				if (held_slots.size() != 0 && $urandom_range(0, 7) != 0)
					idx = held_slots[$urandom_range(0, held_slots.size() - 1)];
				issue_word(MODE_FREE, {$urandom, $urandom}, idx, BLK_W'($urandom), r);
				sent++;
			end else if (pick < 90) begin
				if (held_slots.size() != 0 && $urandom_range(0, 1) == 0)
					idx = held_slots[$urandom_range(0, held_slots.size() - 1)];
				issue_word(MODE_WRITE, {$urandom, $urandom}, idx, blk, r);
				sent++;
			end else begin
				issue_word(mode_t'($urandom_range(0, 3)), {$urandom, $urandom},
					IDX_W'($urandom), ($urandom_range(0, 3) == 0) ? '0 : BLK_W'($urandom), r);
				sent++;
			end
			// sender holds off until everything is back
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end
	endtask

	task automatic test_random_traffic();
		random_phase(CNT_W'(70), 105);
		random_phase(CNT_W'(64), 105);
		random_phase(CNT_W'(1), 105);
		random_phase(CNT_W'(100), 105);
		random_phase(CNT_W'(4096), 105);
		random_phase('1, 105);
		random_phase(CNT_MAX, 105);
		random_phase(CNT_W'($urandom_range(1, 131071)), 105);
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_count_clamping();
		test_partial_region();
		test_random_traffic();
		drain_results();
		// idle on after draining, to catch stray strobes
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("words never returned", 32'(pending_results.size()), 32'(0));
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
